// ----- src/hfss_pkg.sv -----
// Shared types and constants for the scaled hidden-Markov forward scorer.
package hfss_pkg;

  localparam int PROB_W          = 16;
  localparam int OUT_SUM_W       = 32;
  localparam int CFG_W           = 4;
  localparam int NUM_STATES_DEF  = 8;
  localparam int NUM_SYMBOLS_DEF = 64;
  localparam logic [CFG_W-1:0] STATES_IN_USE_RST = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD_INIT  = 2'd0,
    OP_LOAD_TRANS = 2'd1,
    OP_LOAD_EMIS  = 2'd2,
    OP_OBSERVE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_VAL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

  // Control word broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load_init;
    logic load_trans;
    logic load_emis;
    logic ring_load;
    logic rot;
    logic val_en;
    logic sum_shift;
    logic div_init;
    logic div_step;
    logic alpha_wr;
    logic alpha_clr;
    logic start;
    logic sym_ok;
  } cell_ctrl_t;

endpackage

// ----- src/hfss_cell.sv -----
// One state cell: tables for its state, alpha, ring stage, sum stage and divider.
module hfss_cell #(
  parameter int NUM_STATES  = 8,
  parameter int NUM_SYMBOLS = 64,
  parameter int IDX         = 0,
  localparam int SW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1,
  localparam int YW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1,
  localparam int NW   = $clog2(NUM_STATES + 1),
  localparam int ACCW = 32 + $clog2(NUM_STATES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hfss_pkg::cell_ctrl_t ctrl_i,
  input  logic [NW-1:0]      n_i,
  input  logic [5:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic [15:0]        prob_i,
  input  logic [YW-1:0]      sym_i,
  input  logic [15:0]        circ_i,
  input  logic [SW-1:0]      src_i,
  output logic [15:0]        circ_o,
  output logic [SW-1:0]      src_o,
  input  logic [31:0]        vs_i,
  output logic [31:0]        vs_o,
  input  logic [ACCW-1:0]    sum_i
);
  import hfss_pkg::*;

  logic [15:0]     tmem [NUM_STATES];
  logic [15:0]     emem [NUM_SYMBOLS];
  logic [15:0]     init_q, alpha_q, circ_q, a_q, tr_q, em_q;
  logic [SW-1:0]   src_q;
  logic            a_v_q, p_v_q, sat_q;
  logic [31:0]     prod_q, val_q, vs_q;
  logic [ACCW-1:0] acc_q, r_q;
  logic [15:0]     q_q;
  logic            col_hit, active, src_ok, ge;
  logic [15:0]     pre, pre_use, em_use;
  logic [31:0]     val_d;
  logic [ACCW:0]   r2;

  assign col_hit = (32'(col_i) == IDX);
  assign active  = (n_i > NW'(IDX));
  assign src_ok  = (NW'(src_q) < n_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_trans && col_hit) tmem[SW'(row_i)] <= prob_i;
    if (ctrl_i.load_emis && col_hit) emem[YW'(row_i)] <= prob_i;
    em_q <= emem[sym_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_init && col_hit) init_q <= prob_i;
    if (ctrl_i.ring_load) begin
      circ_q <= alpha_q;
      src_q  <= SW'(IDX);
    end else if (ctrl_i.rot) begin
      circ_q <= circ_i;
      src_q  <= src_i;
    end
    if (ctrl_i.rot) begin
      a_q  <= src_ok ? circ_q : '0;
      tr_q <= src_ok ? tmem[src_q] : '0;
    end
    prod_q <= a_q * tr_q;
    if (ctrl_i.ring_load) acc_q <= '0;
    else if (p_v_q) acc_q <= acc_q + ACCW'(prod_q);
    if (ctrl_i.val_en) begin
      val_q <= val_d;
      vs_q  <= val_d;
    end else if (ctrl_i.sum_shift) begin
      vs_q <= vs_i;
    end
    if (ctrl_i.div_init) begin
      r_q   <= ACCW'(val_q);
      sat_q <= (ACCW'(val_q) == sum_i);
      q_q   <= '0;
    end else if (ctrl_i.div_step) begin
      r_q <= ge ? ACCW'(r2 - {1'b0, sum_i}) : ACCW'(r2);
      q_q <= {q_q[14:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
      a_v_q   <= 1'b0;
      p_v_q   <= 1'b0;
    end else begin
      a_v_q <= ctrl_i.rot;
      p_v_q <= a_v_q;
      if (ctrl_i.alpha_clr) alpha_q <= '0;
      else if (ctrl_i.alpha_wr) alpha_q <= !active ? '0 : (sat_q ? 16'hFFFF : q_q);
    end
  end

  always_comb begin
    if (ctrl_i.start) pre = init_q;
    else if (acc_q[ACCW-1:32] != '0) pre = 16'hFFFF;
    else pre = acc_q[31:16];
    pre_use = active ? pre : '0;
    em_use  = (active && ctrl_i.sym_ok) ? em_q : '0;
    val_d   = pre_use * em_use;
    r2      = {r_q, 1'b0};
    ge      = (r2 >= {1'b0, sum_i});
  end

  assign circ_o = circ_q;
  assign src_o  = src_q;
  assign vs_o   = vs_q;

endmodule

// ----- src/hmm_forward_scaled_scoring.sv -----
// Top level of the scaled hidden-Markov forward scorer: sequencer and cell chain.
//
// The block holds one cell per hidden state in a ring. Load requests write the
// initial, transition and emission tables and give no result. The normalized
// alpha vector travels once around the ring of cells while each cell
// accumulates its transition sum through its operand, product and accumulator
// registers. The products with the emissions are then formed, shifted out of
// the chain and added. Every cell then runs a restoring division of its value
// by the step sum, and the write-back state stores alpha and registers the
// result. A zero step sum skips the division. One result follows each
// observation. The next request can be taken in the cycle after the result is
// registered, while that result still waits; a new observation is not taken
// before the last one is through. The write-back state stalls as long as an
// earlier result has not been taken.
// The user must write states_in_use over the configuration channel only while
// the block is idle; the block itself does not enforce it. Zero acts as one
// and values above NUM_STATES act as NUM_STATES.
module hmm_forward_scaled_scoring #(
  parameter int NUM_STATES  = hfss_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = hfss_pkg::NUM_SYMBOLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  row_index_i,
  input  logic [2:0]  col_index_i,
  input  logic [15:0] prob_value_i,
  input  logic [5:0]  symbol_i,
  input  logic        seq_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] step_sum_o,
  output logic        zero_sum_o
);
  import hfss_pkg::*;

  localparam int SW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int YW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int NW   = $clog2(NUM_STATES + 1);
  localparam int ACCW = 32 + $clog2(NUM_STATES);
  localparam int CW   = $clog2(NUM_STATES + 18);

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CFG_W-1:0] siu_q;
  logic [NW-1:0]    n_act;
  logic [5:0]       sym_q;
  logic             start_q, sym_ok_q;
  logic [ACCW-1:0]  sum_q;
  logic             out_valid_q, zero_q;
  logic [31:0]      out_sum_q;
  logic             in_acc, obs_acc, out_free, emit;
  cell_ctrl_t       ctrl;

  logic [15:0]   circ_w [NUM_STATES];
  logic [SW-1:0] src_w  [NUM_STATES];
  logic [31:0]   vs_w   [NUM_STATES];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign obs_acc     = in_acc && (opcode_e'(opcode_i) == OP_OBSERVE);
  assign out_free    = !out_valid_q || out_ready_i;

  // Active state count, clamped to the built range.
  always_comb begin
    if (siu_q == '0) n_act = NW'(1);
    else if (32'(siu_q) > NUM_STATES) n_act = NW'(NUM_STATES);
    else n_act = NW'(siu_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      siu_q       <= STATES_IN_USE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) siu_q <= cfg_data_i;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (obs_acc) begin
      sym_q    <= symbol_i;
      start_q  <= seq_start_i;
      sym_ok_q <= (32'(symbol_i) < NUM_SYMBOLS);
    end
    if (state_q == ST_VAL) sum_q <= '0;
    else if (state_q == ST_SUM) sum_q <= sum_q + ACCW'(vs_w[0]);
    if (emit) begin
      out_sum_q <= (sum_q[ACCW-1:32] != '0) ? 32'hFFFF_FFFF : sum_q[31:0];
      zero_q    <= (sum_q == '0);
    end
  end

  // Sequencer: next state and the control word for the cells.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    ctrl    = '0;
    ctrl.start  = start_q;
    ctrl.sym_ok = sym_ok_q;
    ctrl.load_init  = in_acc && (opcode_e'(opcode_i) == OP_LOAD_INIT);
    ctrl.load_trans = in_acc && (opcode_e'(opcode_i) == OP_LOAD_TRANS)
                      && (32'(row_index_i) < NUM_STATES);
    ctrl.load_emis  = in_acc && (opcode_e'(opcode_i) == OP_LOAD_EMIS)
                      && (32'(row_index_i) < NUM_SYMBOLS);
    unique case (state_q)
      ST_IDLE: begin
        if (obs_acc) begin
          ctrl.ring_load = 1'b1;
          cnt_d   = '0;
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        ctrl.rot = (cnt_q < CW'(NUM_STATES));
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CW'(NUM_STATES + 2)) begin
          ctrl.rot = 1'b0;
          state_d  = ST_VAL;
        end
      end
      ST_VAL: begin
        ctrl.val_en = 1'b1;
        cnt_d   = '0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        ctrl.sum_shift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(NUM_STATES - 1)) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sum_q == '0) begin
          state_d = ST_DONE;
        end else begin
          ctrl.div_init = (cnt_q == '0);
          ctrl.div_step = (cnt_q != '0);
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CW'(16)) state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          ctrl.alpha_clr = (sum_q == '0);
          ctrl.alpha_wr  = (sum_q != '0);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < NUM_STATES; g++) begin : g_cell
    localparam int NXT = (g + 1) % NUM_STATES;
    logic [31:0] vs_in;
    assign vs_in = (g == NUM_STATES - 1) ? 32'd0 : vs_w[NXT];
    hfss_cell #(
      .NUM_STATES (NUM_STATES),
      .NUM_SYMBOLS(NUM_SYMBOLS),
      .IDX        (g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .n_i   (n_act),
      .row_i (row_index_i),
      .col_i (col_index_i),
      .prob_i(prob_value_i),
      .sym_i (YW'(sym_q)),
      .circ_i(circ_w[NXT]),
      .src_i (src_w[NXT]),
      .circ_o(circ_w[g]),
      .src_o (src_w[g]),
      .vs_i  (vs_in),
      .vs_o  (vs_w[g]),
      .sum_i (sum_q)
    );
  end

  assign out_valid_o = out_valid_q;
  assign step_sum_o  = out_sum_q;
  assign zero_sum_o  = zero_q;

endmodule
